// ----- rtl/core/pllu_pkg.sv -----
package pllu_pkg;

   // Fixed field widths of the request and response channels
   localparam int unsigned KEY_W = 32;
   localparam int unsigned PAYLOAD_PORT_W = 64;
   localparam int unsigned MODE_W = 3;
   localparam int unsigned STATUS_W = 3;

   // Request opcodes
   typedef enum logic [MODE_W-1:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_BACK  = 3'd1,
      MODE_INS_AT    = 3'd2,
      MODE_RM_FRONT  = 3'd3,
      MODE_RM_BACK   = 3'd4,
      MODE_RM_AT     = 3'd5,
      MODE_LOOKUP    = 3'd6
   } mode_type;

   // Response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // What a cell does with its entry at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD       = 2'd0,
      CELL_LOAD       = 2'd1,
      CELL_TAKE_LEFT  = 2'd2,
      CELL_TAKE_RIGHT = 2'd3
   } cell_op_type;

   // Control handed to each cell by the top level
   typedef struct packed {
      cell_op_type op;
      logic        occupied;
   } cell_ctl_type;

endpackage

// ----- rtl/core/pllu_cell.sv -----
// One list slot: holds a key and payload, shifts with its neighbors, and
// forms one stage of the lookup wave that runs from slot 0 upward.
module pllu_cell
   import pllu_pkg::*;
#(
   parameter int unsigned PAYLOAD_BITS = 64
) (
   input  logic                    clock,
   input  cell_ctl_type            ctl,
   input  logic signed [KEY_W-1:0] new_key,
   input  logic [PAYLOAD_BITS-1:0] new_payload,
   input  logic signed [KEY_W-1:0] left_key,
   input  logic [PAYLOAD_BITS-1:0] left_payload,
   input  logic signed [KEY_W-1:0] right_key,
   input  logic [PAYLOAD_BITS-1:0] right_payload,
   output logic signed [KEY_W-1:0] key_out,
   output logic [PAYLOAD_BITS-1:0] payload_out,
   input  logic signed [KEY_W-1:0] search_key,
   input  logic                    hit_prev,
   input  logic [PAYLOAD_BITS-1:0] data_prev,
   output logic                    hit_out,
   output logic [PAYLOAD_BITS-1:0] data_out
);

   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic hit_ff, hit_in;
   logic [PAYLOAD_BITS-1:0] data_ff, data_in;
   logic match;

   // entry update: keep, load new, or shift from a neighbor
   always_comb begin
      case (ctl.op)
         CELL_LOAD: begin
            key_in = new_key;
            payload_in = new_payload;
         end
         CELL_TAKE_LEFT: begin
            key_in = left_key;
            payload_in = left_payload;
         end
         CELL_TAKE_RIGHT: begin
            key_in = right_key;
            payload_in = right_payload;
         end
         default: begin
            key_in = key_ff;
            payload_in = payload_ff;
         end
      endcase
   end

   // lookup wave: a higher slot's match overrides what arrives from below
   assign match = ctl.occupied && (key_ff == search_key);
   assign hit_in = match | hit_prev;
   assign data_in = match ? payload_ff : data_prev;

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      payload_ff <= payload_in;
      hit_ff <= hit_in;
      data_ff <= data_in;
   end

   assign key_out = key_ff;
   assign payload_out = payload_ff;
   assign hit_out = hit_ff;
   assign data_out = data_ff;

endmodule

// ----- rtl/core/positional_list_with_key_lookup_unit.sv -----
// Positional list with key lookup.
// Request channel (req_valid/req_ready): mode, position, key, payload.
// Response channel (rsp_valid/rsp_ready): status, found payload and the
// entry count after the request; exactly one response per request.
// Inserts and removes update the list as they are taken: the response is valid
// the cycle after the request is taken, and a new request can be taken every
// cycle while the receiver keeps up.
// A lookup sends the key up the row of slots, one slot per cycle, and its
// response loads once the key has passed the whole slot chain and the output
// register is free; no request is taken meanwhile, and the next one is taken
// only after the response loads, once the block is back in idle.
// The response sits in an output register; a request is taken while that
// register is empty or being drained in the same cycle. When the receiver
// stalls, the response holds and, once the register stays full, req_ready
// drops. Reset empties the list and drops rsp_valid; slot contents are not
// cleared, only the entry count.
module positional_list_with_key_lookup_unit
   import pllu_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned PAYLOAD_BITS = 64,
   localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [MODE_W-1:0]         req_mode,
   input  logic [CNT_W-1:0]          req_position,
   input  logic signed [KEY_W-1:0]   req_key,
   input  logic [PAYLOAD_PORT_W-1:0] req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [PAYLOAD_PORT_W-1:0] rsp_found_payload,
   output logic [CNT_W-1:0]          rsp_entry_count
);

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } state_type;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic signed [KEY_W-1:0] skey_ff, skey_in;
   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [PAYLOAD_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic req_fire;
   logic out_free;
   logic is_ins, is_rm;
   logic [CNT_W-1:0] req_at;
   status_type req_status;
   logic do_ins, do_rm;
   logic [CNT_W-1:0] cnt_next;
   logic [PAYLOAD_BITS-1:0] new_payload;

   logic signed [KEY_W-1:0] cell_key [DEPTH];
   logic [PAYLOAD_BITS-1:0] cell_payload [DEPTH];
   logic wave_hit [DEPTH+1];
   logic [PAYLOAD_BITS-1:0] wave_data [DEPTH+1];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign req_fire = req_valid && req_ready;
   assign new_payload = req_payload[PAYLOAD_BITS-1:0];

   // request decode: target slot and outcome
   always_comb begin
      is_ins = 1'b0;
      is_rm = 1'b0;
      req_at = '0;
      case (req_mode)
         MODE_INS_FRONT: begin
            is_ins = 1'b1;
         end
         MODE_INS_BACK: begin
            is_ins = 1'b1;
            req_at = cnt_ff;
         end
         MODE_INS_AT: begin
            is_ins = 1'b1;
            req_at = req_position;
         end
         MODE_RM_FRONT: begin
            is_rm = 1'b1;
         end
         MODE_RM_BACK: begin
            is_rm = 1'b1;
            req_at = cnt_ff - CNT_W'(1);
         end
         MODE_RM_AT: begin
            is_rm = 1'b1;
            req_at = req_position;
         end
         default: begin
         end
      endcase

      req_status = ST_OK;
      if (is_ins) begin
         if (cnt_ff == DEPTH_C) req_status = ST_FULL;
         else if (req_at > cnt_ff) req_status = ST_BADPOS;
      end else if (is_rm) begin
         if (cnt_ff == '0) req_status = ST_EMPTY;
         else if (req_at >= cnt_ff) req_status = ST_BADPOS;
      end

      do_ins = req_fire && is_ins && (req_status == ST_OK);
      do_rm = req_fire && is_rm && (req_status == ST_OK);

      cnt_next = cnt_ff;
      if (do_ins) cnt_next = cnt_ff + CNT_W'(1);
      else if (do_rm) cnt_next = cnt_ff - CNT_W'(1);
   end

   // row of slots
   assign wave_hit[0] = 1'b0;
   assign wave_data[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);
      cell_ctl_type ctl;
      logic signed [KEY_W-1:0] lkey, rkey;
      logic [PAYLOAD_BITS-1:0] lpay, rpay;

      // per-slot shift decision
      always_comb begin
         ctl.occupied = CELL_IDX < cnt_ff;
         ctl.op = CELL_HOLD;
         if (do_ins) begin
            if (CELL_IDX == req_at) ctl.op = CELL_LOAD;
            else if (CELL_IDX > req_at && CELL_IDX <= cnt_ff) ctl.op = CELL_TAKE_LEFT;
         end else if (do_rm) begin
            if (CELL_IDX >= req_at && CELL_IDX < cnt_ff - CNT_W'(1)) begin
               ctl.op = CELL_TAKE_RIGHT;
            end
         end
      end

      if (i == 0) begin : g_first
         assign lkey = req_key;
         assign lpay = new_payload;
      end else begin : g_mid
         assign lkey = cell_key[i-1];
         assign lpay = cell_payload[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign rkey = cell_key[i];
         assign rpay = cell_payload[i];
      end else begin : g_inner
         assign rkey = cell_key[i+1];
         assign rpay = cell_payload[i+1];
      end

      pllu_cell #(
         .PAYLOAD_BITS(PAYLOAD_BITS)
      ) u_cell (
         .clock(clock),
         .ctl(ctl),
         .new_key(req_key),
         .new_payload(new_payload),
         .left_key(lkey),
         .left_payload(lpay),
         .right_key(rkey),
         .right_payload(rpay),
         .key_out(cell_key[i]),
         .payload_out(cell_payload[i]),
         .search_key(skey_ff),
         .hit_prev(wave_hit[i]),
         .data_prev(wave_data[i]),
         .hit_out(wave_hit[i+1]),
         .data_out(wave_data[i+1])
      );
   end

   // sequencer and response register next values
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_next;
      scan_in = scan_ff;
      skey_in = skey_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_LOOKUP) begin
                  state_in = S_SEARCH;
                  scan_in = '0;
                  skey_in = req_key;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = req_status;
                  rsp_data_in = '0;
                  rsp_count_in = cnt_next;
               end
            end
         end
         S_SEARCH: begin
            // slot k has seen the key once scan reaches k+1
            if (scan_ff != DEPTH_C) begin
               scan_in = scan_ff + CNT_W'(1);
            end else if (out_free) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_status_in = wave_hit[DEPTH] ? ST_OK : ST_NOTFOUND;
               rsp_data_in = wave_data[DEPTH];
               rsp_count_in = cnt_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      skey_ff <= skey_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_payload = PAYLOAD_PORT_W'(rsp_data_ff);
   assign rsp_entry_count = rsp_count_ff;

   // list never grows past its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_C)
      else $error("entry count above depth");

   // count moves only on a taken request, and by one at most
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(cnt_ff))
      else $error("entry count changed without a request");

   // a miss never carries payload data
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NOTFOUND) |-> (rsp_found_payload == '0))
      else $error("not-found response with nonzero payload");

   // a lookup holds the list still until its response is loaded
   a_search_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |=> (cnt_ff == $past(cnt_ff)))
      else $error("list changed during lookup");

endmodule

// ----- tb/tb_positional_list_with_key_lookup_unit.sv -----
module tb_positional_list_with_key_lookup_unit;
   import pllu_pkg::*;

   localparam int unsigned DEPTH = 16;
   localparam int unsigned PAYLOAD_BITS = 64;
   localparam int unsigned POS_W = $clog2(DEPTH + 1);
   localparam int unsigned CYCLE_LIMIT = 200_000;
   localparam int unsigned IDLE_PCT = 32;
   localparam int unsigned MAX_PRINTS = 40;

   // mode code the block leaves unused; the request must do nothing
   localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

   // operation mixes for the random rounds
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_kind_type;

   // list predictor plus queue of expected responses
   class list_scoreboard;
      typedef struct {
         status_type          status;
         logic [63:0]         found;
         logic [POS_W-1:0]    count;
      } list_result_type;

      logic [KEY_W-1:0] keys[$];
      logic [63:0]      payloads[$];
      list_result_type  expected[$];
      int unsigned      depth;
      logic [63:0]      payload_mask;
      int unsigned      n_requests;
      int unsigned      n_responses;
      int unsigned      n_status[5];
      int unsigned      n_hits;
      int unsigned      peak_entries;

      function new(int unsigned depth_i, int unsigned payload_bits_i);
         depth = depth_i;
         payload_mask = (payload_bits_i >= 64) ? '1 : ((64'd1 << payload_bits_i) - 64'd1);
      endfunction

      function int unsigned entries();
         return keys.size();
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction

      function status_type insert_entry(int unsigned at, logic [KEY_W-1:0] key,
                                        logic [63:0] payload);
         if (keys.size() >= depth) return ST_FULL;
         if (at > keys.size()) return ST_BADPOS;
         keys.insert(at, key);
         payloads.insert(at, payload & payload_mask);
         return ST_OK;
      endfunction

      function status_type remove_entry(int unsigned at);
         if (keys.size() == 0) return ST_EMPTY;
         if (at >= keys.size()) return ST_BADPOS;
         keys.delete(at);
         payloads.delete(at);
         return ST_OK;
      endfunction

      // apply one accepted request and queue the response it must give
      function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                 logic [KEY_W-1:0] key, logic [63:0] payload);
         list_result_type res;
         res.status = ST_OK;
         res.found = '0;
         case (mode)
            MODE_INS_FRONT: res.status = insert_entry(0, key, payload);
            MODE_INS_BACK:  res.status = insert_entry(keys.size(), key, payload);
            MODE_INS_AT:    res.status = insert_entry(pos, key, payload);
            MODE_RM_FRONT:  res.status = remove_entry(0);
            MODE_RM_BACK:   res.status = remove_entry(keys.size() == 0 ? 0 : keys.size() - 1);
            MODE_RM_AT:     res.status = remove_entry(pos);
            MODE_LOOKUP: begin
               // last match wins
               res.status = ST_NOTFOUND;
               foreach (keys[i]) begin
                  if (keys[i] == key) begin
                     res.found = payloads[i];
                     res.status = ST_OK;
                  end
               end
               if (res.status == ST_OK) n_hits++;
            end
            default: ;
         endcase
         res.found &= payload_mask;
         res.count = POS_W'(keys.size());
         if (keys.size() > peak_entries) peak_entries = keys.size();
         n_status[res.status]++;
         n_requests++;
         expected.push_back(res);
      endfunction

      // compare one response with the oldest expectation; "" means it matched
      function string check_response(logic [STATUS_W-1:0] status, logic [63:0] found,
                                     logic [POS_W-1:0] count);
         list_result_type exp;
         string msg;
         msg = "";
         n_responses++;
         if (expected.size() == 0)
            return $sformatf("response %0d with no request pending (status %0d count %0d)",
                             n_responses, status, count);
         exp = expected.pop_front();
         if (status !== exp.status)
            msg = {msg, $sformatf(" status %0d expected %s", status, exp.status.name())};
         if (found !== exp.found)
            msg = {msg, $sformatf(" found_payload %h expected %h", found, exp.found)};
         if (count !== exp.count)
            msg = {msg, $sformatf(" entry_count %0d expected %0d", count, exp.count)};
         if (msg != "") msg = $sformatf("response %0d:%s", n_responses, msg);
         return msg;
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [MODE_W-1:0]         req_mode = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [KEY_W-1:0]   req_key = '0;
   logic [PAYLOAD_PORT_W-1:0] req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [PAYLOAD_PORT_W-1:0] rsp_found_payload;
   logic [POS_W-1:0]          rsp_entry_count;

   list_scoreboard sb = new(DEPTH, PAYLOAD_BITS);
   int unsigned    cycles = 0;
   int unsigned    errors = 0;
   bit             no_gaps = 1'b0;

   // keys reused often so lookups hit and duplicates form
   logic [KEY_W-1:0] key_pool[8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                     32'hffff_ffff, 32'h0000_0001, 32'h1234_5678,
                                     32'hdead_beef, 32'h0000_0100};

   positional_list_with_key_lookup_unit #(
      .DEPTH(DEPTH),
      .PAYLOAD_BITS(PAYLOAD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_position(req_position),
      .req_key(req_key),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_found_payload(rsp_found_payload),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH cycle %0d: %s", cycles, what);
   endtask

   // cycle count and run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles, sb.pending());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: check what was taken this edge, then pick next ready
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_valid && rsp_ready) begin
         msg = sb.check_response(rsp_status, rsp_found_payload, rsp_entry_count);
         if (msg != "") report_mismatch(msg);
      end
      rsp_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
   end

   // present one request and hold it until taken
   task send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                     input logic [KEY_W-1:0] key, input logic [63:0] payload);
      if (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_position <= pos;
      req_key <= key;
      req_payload <= payload;
      do @(posedge clock); while (!req_ready);
      sb.note_request(mode, pos, key, payload);
   endtask

   function logic [MODE_W-1:0] pick_mode(mix_kind_type kind);
      int unsigned cut[7];
      int unsigned r;
      r = $urandom_range(99);
      case (kind)
         MIX_FILL:  cut = '{25, 45, 70, 75, 80, 85, 98};
         MIX_DRAIN: cut = '{8, 16, 24, 42, 60, 82, 98};
         default:   cut = '{15, 30, 45, 57, 69, 81, 98};
      endcase
      for (int i = 0; i < 7; i++)
         if (r < cut[i]) return MODE_W'(i);
      return MODE_UNUSED;
   endfunction

   task run_random(input int unsigned n, input mix_kind_type kind);
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [KEY_W-1:0]  key;
      logic [63:0]       payload;
      int unsigned       cnt;
      int unsigned       r;
      repeat (n) begin
         cnt = sb.entries();
         mode = pick_mode(kind);
         // mostly legal positions, some anywhere in the field
         if (mode == MODE_INS_AT && $urandom_range(99) < 75)
            pos = POS_W'($urandom_range(cnt));
         else if (mode == MODE_RM_AT && cnt > 0 && $urandom_range(99) < 75)
            pos = POS_W'($urandom_range(cnt - 1));
         else
            pos = POS_W'($urandom_range(2 ** POS_W - 1));
         key = ($urandom_range(99) < 60) ? key_pool[$urandom_range(7)] : $urandom;
         r = $urandom_range(99);
         if (r < 5) payload = '1;
         else if (r < 10) payload = '0;
         else payload = {$urandom, $urandom};
         send_request(mode, pos, key, payload);
      end
   endtask

   initial begin
      mix_kind_type rounds[10];
      rounds = '{MIX_FILL, MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_DRAIN,
                 MIX_BALANCED, MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_BALANCED};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, bad positions, extremes, duplicates, unused mode
      send_request(MODE_LOOKUP, 0, 32'h0, 64'h0);
      send_request(MODE_RM_FRONT, 0, 32'h0, 64'h0);
      send_request(MODE_RM_BACK, 0, 32'h0, 64'h0);
      send_request(MODE_RM_AT, 0, 32'h0, 64'h0);
      send_request(MODE_INS_AT, 1, 32'h1, 64'h1);
      send_request(MODE_INS_AT, 0, 32'h7fff_ffff, '1);
      send_request(MODE_INS_FRONT, 0, 32'h8000_0000, 64'h0);
      send_request(MODE_INS_BACK, 0, 32'h0, 64'h5555_5555_5555_5555);
      send_request(MODE_INS_AT, 3, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(MODE_INS_AT, 2, 32'h7fff_ffff, 64'h0123_4567_89ab_cdef);
      send_request(MODE_LOOKUP, 0, 32'h7fff_ffff, 64'h0);
      send_request(MODE_LOOKUP, 0, 32'h8000_0000, 64'h0);
      send_request(MODE_UNUSED, 31, 32'hdead_beef, '1);
      send_request(MODE_LOOKUP, 0, 32'h1234_5678, 64'h0);
      send_request(MODE_RM_AT, 5, 32'h0, 64'h0);
      send_request(MODE_RM_AT, 31, 32'h0, 64'h0);
      send_request(MODE_INS_AT, 31, 32'h2, 64'h2);
      send_request(MODE_RM_AT, 2, 32'h0, 64'h0);
      send_request(MODE_RM_FRONT, 0, 32'h0, 64'h0);
      send_request(MODE_RM_BACK, 0, 32'h0, 64'h0);
      send_request(MODE_LOOKUP, 0, 32'hffff_ffff, 64'h0);
      send_request(MODE_LOOKUP, 0, 32'h0, 64'h0);

      // random rounds; the third runs with both sides never idling
      foreach (rounds[i]) begin
         no_gaps = (i == 2);
         run_random(100, rounds[i]);
      end
      no_gaps = 1'b0;
      req_valid <= 1'b0;

      // drain, then allow a full lookup time for anything stray
      while (sb.pending() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (sb.pending() != 0) report_mismatch($sformatf("%0d responses never came",
                                                       sb.pending()));

      $display("%0d requests: %0d ok, %0d full, %0d empty, %0d bad position, %0d not found",
               sb.n_requests, sb.n_status[ST_OK], sb.n_status[ST_FULL],
               sb.n_status[ST_EMPTY], sb.n_status[ST_BADPOS], sb.n_status[ST_NOTFOUND]);
      $display("lookup hits %0d, peak list length %0d of %0d, %0d mismatches",
               sb.n_hits, sb.peak_entries, DEPTH, errors);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/pllu_pkg.sv
rtl/core/pllu_cell.sv
rtl/core/positional_list_with_key_lookup_unit.sv
tb/tb_positional_list_with_key_lookup_unit.sv
